/* sv/midi_note_merge_counter_macros.svh */
// ----------------------------------------------------------------------------
// midi_note_merge_counter assertion macros
// Shared concurrent assertion wrappers, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_MERGE_COUNTER_MACROS_SVH
`define MIDI_NOTE_MERGE_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MNMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mnmc assertion failed");
`define MNMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mnmc assertion failed");
`else
`define MNMC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MNMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/mnmc_pkg.sv */
// ----------------------------------------------------------------------------
// mnmc_pkg
// Constants and types shared by the note merge counter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mnmc_pkg;

  localparam int NUM_KEYS    = 128;
  localparam int COUNT_WIDTH = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 7;
  localparam int VEL_W  = 7;
  localparam int CHAN_W = 4;
  localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int KCMP_W = 9;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO = '0;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);

  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;

  localparam logic PORT_KEYBOARD = 1'b0;
  localparam logic PORT_PLAYER   = 1'b1;

  typedef struct packed {
    logic              note_on;
    logic              player;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  vel;
  } evt_t;

endpackage

`default_nettype wire

/* sv/midi_note_merge_counter.sv */
// ----------------------------------------------------------------------------
// midi_note_merge_counter
// Merges keyboard and player note events through per-key hold counts.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low; unsupported kinds
// and keys beyond the table are dropped at once. Kept events wait in a
// two-entry queue and are then processed one at a time: a counter RAM
// read, then update and emit; a keyboard note-on on a key whose hold
// count is one re-triggers it, emitting a note-off followed by a note-on.
// The counter RAM is read-modify-written per event; busy rises only when the
// queue is full. Each result is on the out_ ports for one cycle with
// out_strobe high and must be taken then, there is no back-pressure;
// out_last marks the final result of an event. Hold counts are zero after
// reset with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_merge_counter
  import mnmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CHAN_W-1:0] cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   in_opcode,
  input  wire logic              in_source_port,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [VEL_W-1:0]  in_velocity,
  output logic                   out_strobe,
  output logic                   out_is_note_on,
  output logic [KEY_W-1:0]       out_key,
  output logic [VEL_W-1:0]       out_velocity,
  output logic [CHAN_W-1:0]      out_channel,
  output logic                   out_last
);

  logic [CHAN_W-1:0] channel_r;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  evt_t              push_evt;
  evt_t              pop_evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r <= '0;
    end else if (cfg_we) begin
      channel_r <= cfg_wdata;
    end
  end

  mnmc_front u_front (
    .start          (start),
    .in_opcode      (in_opcode),
    .in_source_port (in_source_port),
    .in_key         (in_key),
    .in_velocity    (in_velocity),
    .q_full         (q_full),
    .busy           (busy),
    .q_push         (q_push),
    .q_evt          (push_evt)
  );

  mnmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_evt (push_evt),
    .pop      (q_pop),
    .pop_evt  (pop_evt),
    .empty    (q_empty),
    .full     (q_full)
  );

  mnmc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_evt          (pop_evt),
    .q_pop          (q_pop),
    .channel        (channel_r),
    .out_strobe     (out_strobe),
    .out_is_note_on (out_is_note_on),
    .out_key        (out_key),
    .out_velocity   (out_velocity),
    .out_channel    (out_channel),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

/* sv/mnmc_ram.sv */
// ----------------------------------------------------------------------------
// mnmc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mnmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/mnmc_queue.sv */
// ----------------------------------------------------------------------------
// mnmc_queue
// Short event queue between the front end and the counter back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midi_note_merge_counter_macros.svh"

module mnmc_queue
  import mnmc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire evt_t push_evt,
  input  wire logic pop,
  output evt_t      pop_evt,
  output logic      empty,
  output logic      full
);

  evt_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign empty   = (count_r == '0);
  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_evt = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_evt;
    end
  end

  `MNMC_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full)
  `MNMC_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty)
  `MNMC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

/* sv/mnmc_front.sv */
// ----------------------------------------------------------------------------
// mnmc_front
// Takes input events, drops ignored kinds and out-of-range keys, and
// queues the rest for the counter back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mnmc_front
  import mnmc_pkg::*;
(
  input  wire logic             start,
  input  wire logic [OP_W-1:0]  in_opcode,
  input  wire logic             in_source_port,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VEL_W-1:0] in_velocity,
  input  wire logic             q_full,
  output logic                  busy,
  output logic                  q_push,
  output evt_t                  q_evt
);

  logic op_ok;
  logic key_ok;

  assign busy   = q_full;
  assign op_ok  = (in_opcode == OP_NOTE_OFF) || (in_opcode == OP_NOTE_ON);
  assign key_ok = (KCMP_W'(in_key) < KCMP_W'(NUM_KEYS));
  assign q_push = start && !q_full && op_ok && key_ok;

  always_comb begin
    q_evt.note_on = (in_opcode == OP_NOTE_ON);
    q_evt.player  = (in_source_port == PORT_PLAYER);
    q_evt.addr    = ADDR_W'(in_key);
    q_evt.key     = in_key;
    q_evt.vel     = in_velocity;
  end

endmodule

`default_nettype wire

/* sv/mnmc_back.sv */
// ----------------------------------------------------------------------------
// mnmc_back
// Per-key hold count read-modify-write and message emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midi_note_merge_counter_macros.svh"

module mnmc_back
  import mnmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire evt_t              q_evt,
  output logic                   q_pop,
  input  wire logic [CHAN_W-1:0] channel,
  output logic                   out_strobe,
  output logic                   out_is_note_on,
  output logic [KEY_W-1:0]       out_key,
  output logic [VEL_W-1:0]       out_velocity,
  output logic [CHAN_W-1:0]      out_channel,
  output logic                   out_last
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SECOND} state_t;

  state_t                  state_r, state_nxt;
  evt_t                    cur_r, cur_nxt;
  logic [NUM_KEYS-1:0]     valid_r, valid_nxt;
  logic                    rd_valid_r, rd_valid_nxt;
  logic                    strobe_r, strobe_nxt;
  logic                    on_r, on_nxt;
  logic                    last_r, last_nxt;
  logic [CHAN_W-1:0]       chan_r, chan_nxt;
  logic [COUNT_WIDTH-1:0]  rd_data;
  logic [COUNT_WIDTH-1:0]  cnt;
  logic [COUNT_WIDTH-1:0]  cnt_new;
  logic                    wr_en;

  mnmc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_KEYS)
  ) u_count_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_r.addr),
    .wdata (cnt_new),
    .raddr (q_evt.addr),
    .rdata (rd_data)
  );

  assign cnt   = rd_valid_r ? rd_data : COUNT_ZERO;
  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign wr_en = (state_r == S_EXEC);

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    valid_nxt    = valid_r;
    rd_valid_nxt = rd_valid_r;
    strobe_nxt   = 1'b0;
    on_nxt       = on_r;
    last_nxt     = last_r;
    chan_nxt     = chan_r;
    cnt_new      = cnt;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          cur_nxt      = q_evt;
          rd_valid_nxt = valid_r[q_evt.addr];
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        valid_nxt[cur_r.addr] = 1'b1;
        chan_nxt              = channel;
        state_nxt             = S_IDLE;
        if (!cur_r.player) begin
          if (cur_r.note_on) begin
            cnt_new    = COUNT_ONE;
            strobe_nxt = 1'b1;
            if (cnt == COUNT_ONE) begin
              on_nxt    = 1'b0;
              last_nxt  = 1'b0;
              state_nxt = S_SECOND;
            end else begin
              on_nxt   = 1'b1;
              last_nxt = 1'b1;
            end
          end else begin
            cnt_new    = COUNT_ZERO;
            strobe_nxt = 1'b1;
            on_nxt     = 1'b0;
            last_nxt   = 1'b1;
          end
        end else if (cur_r.note_on) begin
          if (cnt != COUNT_MAX) begin
            cnt_new = cnt + COUNT_ONE;
            if (cnt == COUNT_ZERO) begin
              strobe_nxt = 1'b1;
              on_nxt     = 1'b1;
              last_nxt   = 1'b1;
            end
          end
        end else begin
          if (cnt != COUNT_ZERO) begin
            cnt_new = cnt - COUNT_ONE;
            if (cnt == COUNT_ONE) begin
              strobe_nxt = 1'b1;
              on_nxt     = 1'b0;
              last_nxt   = 1'b1;
            end
          end
        end
      end
      S_SECOND: begin
        strobe_nxt = 1'b1;
        on_nxt     = 1'b1;
        last_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      rd_valid_r <= rd_valid_nxt;
      strobe_r   <= strobe_nxt;
    end
    cur_r  <= cur_nxt;
    on_r   <= on_nxt;
    last_r <= last_nxt;
    chan_r <= chan_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_is_note_on = on_r;
  assign out_key        = cur_r.key;
  assign out_velocity   = cur_r.vel;
  assign out_channel    = chan_r;
  assign out_last       = last_r;

  // a non-final result is always the re-trigger note-off, followed by its note-on
  `MNMC_ASSERT_IMPL(a_first_is_off, clk, rst_n, strobe_r && !last_r, !on_r)
  `MNMC_ASSERT_NEXT(a_second_follows, clk, rst_n, strobe_r && !last_r,
                    strobe_r && last_r && on_r)
  `MNMC_ASSERT_IMPL(a_no_pop_busy, clk, rst_n, state_r != S_IDLE, !q_pop)

endmodule

`default_nettype wire

/* dv/midi_note_merge_counter_tb.sv */
// ----------------------------------------------------------------------------
// midi_note_merge_counter_tb
// Self-checking bench for the keyboard/player note merge counter. Events are
// issued on the start/busy port, directed and random, with random or no spacing. A
// behavioural copy of the per-key hold counts predicts every emitted message,
// and each strobed message is compared against the oldest prediction.
// ----------------------------------------------------------------------------

class note_merge_board;

  typedef struct packed {
    logic                        note_on;
    logic [mnmc_pkg::KEY_W-1:0]  key;
    logic [mnmc_pkg::VEL_W-1:0]  vel;
    logic [mnmc_pkg::CHAN_W-1:0] chan;
    logic                        last;
  } note_msg_t;

  logic [mnmc_pkg::COUNT_WIDTH-1:0] held [mnmc_pkg::NUM_KEYS];
  logic [mnmc_pkg::CHAN_W-1:0]      chan;
  note_msg_t                        pending [$];
  int unsigned                      errors;

  function new();
    foreach (held[k]) held[k] = mnmc_pkg::COUNT_ZERO;
    chan   = '0;
    errors = 0;
  endfunction

  function void emit(logic on, logic [mnmc_pkg::KEY_W-1:0] key,
                     logic [mnmc_pkg::VEL_W-1:0] vel);
    note_msg_t m;
    m.note_on = on;
    m.key     = key;
    m.vel     = vel;
    m.chan    = chan;
    m.last    = 1'b0;
    pending.push_back(m);
  endfunction

  // Update the hold counts for one accepted event and queue its messages
  function void take_event(logic [mnmc_pkg::OP_W-1:0] op, logic port,
                           logic [mnmc_pkg::KEY_W-1:0] key,
                           logic [mnmc_pkg::VEL_W-1:0] vel);
    int unsigned before_n;
    before_n = pending.size();
    if ((op != mnmc_pkg::OP_NOTE_ON && op != mnmc_pkg::OP_NOTE_OFF) ||
        int'(key) >= mnmc_pkg::NUM_KEYS) return;
    if (port == mnmc_pkg::PORT_KEYBOARD) begin
      if (op == mnmc_pkg::OP_NOTE_ON) begin
        if (held[key] == mnmc_pkg::COUNT_ONE) emit(1'b0, key, vel);
        held[key] = mnmc_pkg::COUNT_ONE;
        emit(1'b1, key, vel);
      end else begin
        emit(1'b0, key, vel);
        held[key] = mnmc_pkg::COUNT_ZERO;
      end
    end else begin
      if (op == mnmc_pkg::OP_NOTE_ON) begin
        if (held[key] != mnmc_pkg::COUNT_MAX) begin
          held[key] = held[key] + mnmc_pkg::COUNT_ONE;
          if (held[key] == mnmc_pkg::COUNT_ONE) emit(1'b1, key, vel);
        end
      end else if (held[key] != mnmc_pkg::COUNT_ZERO) begin
        held[key] = held[key] - mnmc_pkg::COUNT_ONE;
        if (held[key] == mnmc_pkg::COUNT_ZERO) emit(1'b0, key, vel);
      end
    end
    if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
  endfunction

  function void check_msg(logic on, logic [mnmc_pkg::KEY_W-1:0] key,
                          logic [mnmc_pkg::VEL_W-1:0] vel,
                          logic [mnmc_pkg::CHAN_W-1:0] ch, logic last);
    note_msg_t want;
    if (pending.size() == 0) begin
      $error("unexpected message: key %0d, note_on %0d", key, on);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (on !== want.note_on) begin
      $error("is_note_on: expected %0d, got %0d", want.note_on, on);
      errors++;
    end
    if (key !== want.key) begin
      $error("out_key: expected %0d, got %0d", want.key, key);
      errors++;
    end
    if (vel !== want.vel) begin
      $error("out_velocity: expected %0d, got %0d", want.vel, vel);
      errors++;
    end
    if (ch !== want.chan) begin
      $error("out_channel: expected %0d, got %0d", want.chan, ch);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, last);
      errors++;
    end
  endfunction

endclass

module midi_note_merge_counter_tb;
  import mnmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_OTHER    = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_GAP       = 13;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CHAN_W-1:0] cfg_wdata;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_opcode;
  logic              in_source_port;
  logic [KEY_W-1:0]  in_key;
  logic [VEL_W-1:0]  in_velocity;
  logic              out_strobe;
  logic              out_is_note_on;
  logic [KEY_W-1:0]  out_key;
  logic [VEL_W-1:0]  out_velocity;
  logic [CHAN_W-1:0] out_channel;
  logic              out_last;

  note_merge_board board = new();
  bit              sender_idles;
  int unsigned     events_sent;

  midi_note_merge_counter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_source_port (in_source_port),
    .in_key         (in_key),
    .in_velocity    (in_velocity),
    .out_strobe     (out_strobe),
    .out_is_note_on (out_is_note_on),
    .out_key        (out_key),
    .out_velocity   (out_velocity),
    .out_channel    (out_channel),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      board.check_msg(out_is_note_on, out_key, out_velocity, out_channel, out_last);
    end
  end

  function automatic logic [VEL_W-1:0] rand_vel();
    return VEL_W'($urandom_range(127));
  endfunction

  task automatic send_event(input logic [OP_W-1:0] op, input logic port,
                            input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] vel);
    int gap;
    gap = sender_idles ? $urandom_range(MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_source_port <= port;
    in_key         <= key;
    in_velocity    <= vel;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.take_event(op, port, key, vel);
    events_sent++;
  endtask

  // drain all predicted messages, then allow for events that emit nothing
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_channel(input logic [CHAN_W-1:0] ch);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= ch;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.chan = ch;
  endtask

  // mostly well-formed press/release and stacked player notes on a few keys
  task automatic random_phase(input int unsigned n_events);
    logic [KEY_W-1:0] pool [6];
    logic [KEY_W-1:0] k;
    int unsigned      target;
    int               kind;
    int               depth;
    foreach (pool[i]) pool[i] = KEY_W'($urandom_range(127));
    target = events_sent + n_events;
    while (events_sent < target) begin
      kind = $urandom_range(99);
      k    = pool[$urandom_range(5)];
      if (kind < 40) begin
        depth = $urandom_range(4, 1);
        repeat (depth) send_event(OP_NOTE_ON, PORT_PLAYER, k, rand_vel());
        if ($urandom_range(3) == 0) begin
          send_event($urandom_range(1) ? OP_NOTE_ON : OP_NOTE_OFF, PORT_KEYBOARD, k,
                     rand_vel());
        end
        repeat (depth) send_event(OP_NOTE_OFF, PORT_PLAYER, k, rand_vel());
      end else if (kind < 65) begin
        send_event(OP_NOTE_ON, PORT_KEYBOARD, k, rand_vel());
        if ($urandom_range(2) == 0) send_event(OP_NOTE_ON, PORT_KEYBOARD, k, rand_vel());
        send_event(OP_NOTE_OFF, PORT_KEYBOARD, k, rand_vel());
      end else begin
        send_event(OP_W'($urandom_range(3)), 1'($urandom_range(1)),
                   KEY_W'($urandom_range(127)), rand_vel());
      end
    end
  endtask

  initial begin
    logic [KEY_W-1:0] skey;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    start          <= 1'b0;
    in_opcode      <= OP_NOTE_OFF;
    in_source_port <= PORT_KEYBOARD;
    in_key         <= '0;
    in_velocity    <= '0;
    sender_idles   = 1'b1;
    events_sent    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_channel(4'd15);
    // keyboard retrigger, note-off on an idle key
    send_event(OP_NOTE_ON,  PORT_KEYBOARD, 7'd0,   7'd127);
    send_event(OP_NOTE_ON,  PORT_KEYBOARD, 7'd0,   7'd0);
    send_event(OP_NOTE_OFF, PORT_KEYBOARD, 7'd0,   7'd85);
    send_event(OP_NOTE_OFF, PORT_KEYBOARD, 7'd127, 7'd127);
    // player stacking, keyboard on a key held twice, off below zero
    send_event(OP_NOTE_ON,  PORT_PLAYER,   7'd127, 7'd42);
    send_event(OP_NOTE_ON,  PORT_PLAYER,   7'd127, 7'd1);
    send_event(OP_NOTE_ON,  PORT_KEYBOARD, 7'd127, 7'd64);
    send_event(OP_NOTE_OFF, PORT_PLAYER,   7'd127, 7'd126);
    send_event(OP_NOTE_OFF, PORT_PLAYER,   7'd127, 7'd3);
    send_event(OP_NOTE_ON,  PORT_PLAYER,   7'd64,  7'd100);
    send_event(OP_NOTE_ON,  PORT_PLAYER,   7'd64,  7'd27);
    send_event(OP_NOTE_OFF, PORT_PLAYER,   7'd64,  7'd77);
    send_event(OP_NOTE_OFF, PORT_PLAYER,   7'd64,  7'd50);
    // ignored kinds leave the count alone
    send_event(OP_OTHER,    PORT_PLAYER,   7'd5,   7'd127);
    send_event(OP_RESERVED, PORT_KEYBOARD, 7'd5,   7'd0);
    send_event(OP_NOTE_ON,  PORT_KEYBOARD, 7'd42,  7'd85);
    send_event(OP_RESERVED, PORT_PLAYER,   7'd42,  7'd42);
    send_event(OP_OTHER,    PORT_KEYBOARD, 7'd42,  7'd42);
    send_event(OP_NOTE_ON,  PORT_KEYBOARD, 7'd42,  7'd21);
    send_event(OP_NOTE_OFF, PORT_PLAYER,   7'd42,  7'd106);

    // counter saturation, back to back
    set_channel(4'd0);
    sender_idles = 1'b0;
    skey = KEY_W'($urandom_range(127));
    for (int i = 0; i < 256; i++) send_event(OP_NOTE_ON, PORT_PLAYER, skey, rand_vel());
    send_event(OP_NOTE_OFF, PORT_PLAYER,   skey, rand_vel());
    send_event(OP_NOTE_ON,  PORT_KEYBOARD, skey, rand_vel());
    send_event(OP_NOTE_OFF, PORT_PLAYER,   skey, rand_vel());

    for (int p = 0; p < 4; p++) begin
      set_channel(CHAN_W'($urandom_range(15)));
      sender_idles = (p % 2 == 0);
      random_phase(210);
    end

    wait_quiet();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
